[src/pstd_pkg.sv]
`default_nettype none
package pstd_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int ID_W       = 8;
  localparam int SLOTF_W    = 8;
  localparam int KIND_W     = 2;
  localparam int DSLOT_W    = 4;
  localparam int STATUS_W   = 3;

  localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_URGENT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN      = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DISPATCH = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd6;

  typedef struct packed {
    logic load;
    logic single;
    logic start_run;
    logic q_step;
    logic q_done;
    logic s_step;
    logic finish;
  } pstd_cmd_t;

  typedef struct packed {
    logic is_run;
    logic out_free;
    logic q_empty;
    logic q_end;
    logic s_end;
  } pstd_sts_t;

endpackage
`default_nettype wire

[src/pstd_ctrl.sv]
`default_nettype none
module pstd_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  pstd_pkg::pstd_sts_t  sts,
  output pstd_pkg::pstd_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_QSCAN = 5'b00100,
    S_SSCAN = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          if (sts.is_run) begin
            cmd.start_run = 1'b1;
            state_next    = sts.q_empty ? S_SSCAN : S_QSCAN;
          end else begin
            cmd.single = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_QSCAN: begin
        if (sts.out_free) begin
          cmd.q_step = 1'b1;
          if (sts.q_end) begin
            cmd.q_done = 1'b1;
            state_next = S_SSCAN;
          end
        end
      end
      S_SSCAN: begin
        if (sts.out_free) begin
          cmd.s_step = 1'b1;
          if (sts.s_end) begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/pstd_dpath.sv]
`default_nettype none
module pstd_dpath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  [pstd_pkg::KIND_W-1:0]         in_kind,
  input  wire  [pstd_pkg::SLOTF_W-1:0]        in_slot,
  input  wire  [pstd_pkg::ID_W-1:0]           in_task_id,
  input  pstd_pkg::pstd_cmd_t                 cmd,
  output pstd_pkg::pstd_sts_t                 sts,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [pstd_pkg::STATUS_W-1:0]       out_status,
  output logic [pstd_pkg::DSLOT_W-1:0]        out_slot,
  output logic                                out_last
);

  logic [pstd_pkg::KIND_W-1:0]  item_kind;
  logic [pstd_pkg::SLOTF_W-1:0] item_slot;
  logic [pstd_pkg::ID_W-1:0]    item_tid;

  logic [pstd_pkg::SLOT_COUNT-1:0] used;
  logic [pstd_pkg::ID_W-1:0]       tid [pstd_pkg::SLOT_COUNT];
  logic [pstd_pkg::ID_W-1:0]       uq  [pstd_pkg::SLOT_COUNT];
  logic [pstd_pkg::CNT_W-1:0]      task_count;
  logic [pstd_pkg::CNT_W-1:0]      ucount;

  logic [pstd_pkg::SLOT_W-1:0] idx;
  logic                        hold_valid;
  logic [pstd_pkg::SLOT_W-1:0] hold_slot;

  logic [pstd_pkg::SLOT_COUNT-1:0] match;
  logic [pstd_pkg::SLOT_COUNT-1:0] in_queue;
  logic                            q_found;
  logic [pstd_pkg::SLOT_W-1:0]     q_slot;
  logic                            in_range;
  logic                            reg_ok;
  logic                            urg_ok;
  logic                            out_free;
  logic [pstd_pkg::SLOT_W-1:0]     wslot;
  logic [pstd_pkg::SLOT_W-1:0]     wq;

  logic                          emit;
  logic [pstd_pkg::STATUS_W-1:0] emit_status;
  logic [pstd_pkg::DSLOT_W-1:0]  emit_slot;
  logic                          emit_last;
  logic                          step_found;
  logic [pstd_pkg::SLOT_W-1:0]   step_slot;

  assign out_free = !out_valid || out_ready;
  assign wslot    = item_slot[pstd_pkg::SLOT_W-1:0];
  assign wq       = ucount[pstd_pkg::SLOT_W-1:0];

  // queued id against every slot, and new id against the live queue entries
  always_comb begin
    for (int j = 0; j < pstd_pkg::SLOT_COUNT; j++) begin
      match[j]    = used[j] && (tid[j] == uq[idx]);
      in_queue[j] = (pstd_pkg::CNT_W'(j) < ucount) && (uq[j] == item_tid);
    end
  end

  // lowest matching slot
  always_comb begin
    q_found = 1'b0;
    q_slot  = '0;
    for (int j = pstd_pkg::SLOT_COUNT - 1; j >= 0; j--) begin
      if (match[j]) begin
        q_found = 1'b1;
        q_slot  = pstd_pkg::SLOT_W'(j);
      end
    end
  end

  assign in_range = item_slot < pstd_pkg::SLOTF_W'(pstd_pkg::SLOT_COUNT);
  assign reg_ok   = in_range && !used[wslot]
                    && (task_count < pstd_pkg::CNT_W'(pstd_pkg::SLOT_COUNT));
  assign urg_ok   = (task_count != '0) && !(|in_queue) && (ucount < task_count);

  assign step_found = cmd.q_step ? q_found : used[idx];
  assign step_slot  = cmd.q_step ? q_slot : idx;

  always_comb begin
    emit        = 1'b0;
    emit_status = pstd_pkg::ST_DISPATCH;
    emit_slot   = pstd_pkg::DSLOT_W'(hold_slot);
    emit_last   = 1'b0;
    if (cmd.single) begin
      emit      = 1'b1;
      emit_slot = '0;
      emit_last = 1'b1;
      case (item_kind)
        pstd_pkg::KIND_REGISTER: begin
          if (!in_range) begin
            emit_status = pstd_pkg::ST_RANGE;
          end else if (!reg_ok) begin
            emit_status = pstd_pkg::ST_TAKEN;
          end else begin
            emit_status = pstd_pkg::ST_ADDED;
          end
        end
        pstd_pkg::KIND_URGENT: begin
          emit_status = urg_ok ? pstd_pkg::ST_QUEUED : pstd_pkg::ST_IGNORED;
        end
        default: begin
          emit_status = pstd_pkg::ST_IGNORED;
        end
      endcase
    end else if (cmd.q_step || cmd.s_step) begin
      // a found slot pushes out the one held back, which is known not to be last
      emit = step_found && hold_valid;
    end else if (cmd.finish) begin
      emit      = 1'b1;
      emit_last = 1'b1;
      if (!hold_valid) begin
        emit_status = pstd_pkg::ST_NONE;
        emit_slot   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      task_count <= '0;
      ucount     <= '0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.single && item_kind == pstd_pkg::KIND_REGISTER && reg_ok) begin
        used[wslot] <= 1'b1;
        task_count  <= task_count + 1'b1;
      end
      if (cmd.single && item_kind == pstd_pkg::KIND_URGENT && urg_ok) begin
        ucount <= ucount + 1'b1;
      end
      if (cmd.start_run) begin
        idx        <= '0;
        hold_valid <= 1'b0;
      end
      if (cmd.q_step || cmd.s_step) begin
        idx <= idx + 1'b1;
        if (step_found) begin
          hold_valid <= 1'b1;
        end
      end
      if (cmd.q_done) begin
        idx    <= '0;
        ucount <= '0;
      end
      if (cmd.finish) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind <= in_kind;
      item_slot <= in_slot;
      item_tid  <= in_task_id;
    end
    if (cmd.single && item_kind == pstd_pkg::KIND_REGISTER && reg_ok) begin
      tid[wslot] <= item_tid;
    end
    if (cmd.single && item_kind == pstd_pkg::KIND_URGENT && urg_ok) begin
      uq[wq] <= item_tid;
    end
    if ((cmd.q_step || cmd.s_step) && step_found) begin
      hold_slot <= step_slot;
    end
    if (emit) begin
      out_status <= emit_status;
      out_slot   <= emit_slot;
      out_last   <= emit_last;
    end
  end

  always_comb begin
    sts.is_run   = item_kind == pstd_pkg::KIND_RUN;
    sts.out_free = out_free;
    sts.q_empty  = ucount == '0;
    sts.q_end    = (pstd_pkg::CNT_W'(idx) + 1'b1) == ucount;
    sts.s_end    = pstd_pkg::CNT_W'(idx) == pstd_pkg::CNT_W'(pstd_pkg::SLOT_COUNT - 1);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    task_count <= pstd_pkg::CNT_W'(pstd_pkg::SLOT_COUNT))
    else $error("task count beyond slot count");

  a_count_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(task_count))
    else $error("task count out of step with occupied slots");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    ucount <= task_count)
    else $error("urgent queue longer than task count");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != pstd_pkg::ST_DISPATCH |-> out_last)
    else $error("non-dispatch result without last");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    emit && !out_free |-> 1'b0)
    else $error("result loaded over a waiting transaction");

endmodule
`default_nettype wire

[src/priority_slot_task_dispatcher_unit.sv]
// a register or urgent result is loaded from the execute state after its input transaction,
// held there while a result waits downstream; a run scans the queued ids in order, then
// every slot, then loads the last result in a final step, each step held likewise
// one item at a time: the next input is taken only after the controller is back in idle,
// once the result of a register or urgent item or the last result of a run is loaded
// rst is synchronous: all slots free, queue empty, no result pending
`default_nettype none
module priority_slot_task_dispatcher_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // slot [7:0], task_id [15:8]
  input  wire  [1:0]  s_tuser,   // kind [1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // dispatch_slot [3:0], zero [7:4]
  output logic [2:0]  m_tuser,   // status [2:0]
  output logic        m_tlast
);

  pstd_pkg::pstd_cmd_t cmd;
  pstd_pkg::pstd_sts_t sts;
  logic [pstd_pkg::DSLOT_W-1:0] dslot;

  pstd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pstd_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_kind    (s_tuser),
    .in_slot    (s_tdata[7:0]),
    .in_task_id (s_tdata[15:8]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_slot   (dslot),
    .out_last   (m_tlast)
  );

  assign m_tdata = {4'b0000, dslot};

endmodule
`default_nettype wire
